// ----- rtl/core/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants for the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int WORD_BITS_DEF = 63;
   localparam int VALUE_BITS    = 63;
   localparam int EXP_BITS      = 64;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_NEG = 3'd2,
      ACT_MUL = 3'd3,
      ACT_DIV = 3'd4,
      ACT_INV = 3'd5,
      ACT_POW = 3'd6,
      ACT_EQ  = 3'd7
   } action_type;

   typedef struct packed {
      action_type                    action;
      logic [VALUE_BITS-1:0]         operand_a;
      logic [VALUE_BITS-1:0]         operand_b;
      logic signed [EXP_BITS-1:0]    exponent;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] result_value;
      logic                  status;
      logic                  is_equal;
   } rsp_type;

endpackage

// ----- rtl/core/mau_divider.sv -----
// ----------------------------------------------------------------------------
// mau_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mau_divider #(
   parameter int W = mau_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);

   localparam int CW = $clog2(W);

   logic          run_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  num_ff;
   logic [W-1:0]  den_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  rem_ff;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   assign shifted = {rem_ff, num_ff[W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            num_ff <= num;
            den_ff <= den;
            rem_ff <= '0;
            quo_ff <= '0;
         end else if (run_ff) begin
            num_ff <= {num_ff[W-2:0], 1'b0};
            quo_ff <= {quo_ff[W-2:0], ~trial[W]};
            rem_ff <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
            if (cnt_ff == CW'(W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/core/mau_mulmod.sv -----
// ----------------------------------------------------------------------------
// mau_mulmod
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mau_mulmod #(
   parameter int W = mau_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] x,
   input  logic [W-1:0] y,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] prod
);

   logic         run_ff;
   logic         done_ff;
   logic [W-1:0] acc_ff;
   logic [W-1:0] xs_ff;
   logic [W-1:0] ys_ff;
   logic [W-1:0] m_ff;

   function automatic logic [W-1:0] add_m(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] md);
      logic [W:0] s;
      logic [W:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, md};
      return d[W] ? s[W-1:0] : d[W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            acc_ff <= '0;
            xs_ff  <= x;
            ys_ff  <= y;
            m_ff   <= m;
         end else if (run_ff) begin
            if (ys_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               if (ys_ff[0]) acc_ff <= add_m(acc_ff, xs_ff, m_ff);
               xs_ff <= add_m(xs_ff, xs_ff, m_ff);
               ys_ff <= ys_ff >> 1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- rtl/core/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular ALU over a programmed modulus: add, sub, negate, mul, div,
// inverse, signed power and equality.
// ----------------------------------------------------------------------------
// usage:
//   write the modulus through csr_we / csr_wdata while the unit is idle; a
//   modulus of zero behaves as one. a transaction is taken when start is high
//   and busy is low; busy falls in the cycle the result is shown.
//   the result appears on rsp_data for one cycle with rsp_valid high; the
//   receiver cannot stall it.
// sequence, run on the bit-serial divider and shift-add multiplier:
//   both operands are first reduced by the divider, then
//   add, sub, negate, equal finish in the dispatch state; mul runs the multiplier
//   inverse: a divide and then a multiply per Euclid step
//   power: a square per exponent bit (up to 64 bits) and a multiply per set bit,
//   plus the inverse for a negative exponent
//   one transaction at a time; the next can be taken in the cycle the
//   result is shown.
// reset: modulus returns to 1, the sequencer goes idle, no result pending.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
   parameter int WORD_BITS = mau_pkg::WORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mau_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output mau_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [mau_pkg::VALUE_BITS-1:0]   csr_wdata
);

   localparam int W = WORD_BITS;
   localparam int EB = mau_pkg::EXP_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_INV_LOOP, S_INV_DIV, S_INV_MUL,
      S_POW, S_POW_ACC, S_POW_SQ, S_POW_SQW, S_MUL_FIN
   } state_type;

   state_type           state_ff;
   mau_pkg::action_type act_ff;
   logic [W-1:0]        mod_ff;
   logic [W-1:0]        meff;
   logic [W-1:0]        a_ff, b_ff, braw_ff;
   logic [EB-1:0]       e_ff;
   logic [EB-1:0]       mag_ff;
   logic [W-1:0]        r0_ff, r1_ff, r2_ff, t0_ff, t1_ff;
   logic [W-1:0]        acc_ff, base_ff;
   logic [W-1:0]        opx_ff, opy_ff;
   logic                div_go_ff, mul_go_ff;
   logic                div_done, mul_done;
   logic [W-1:0]        div_quo, div_rem, mul_prod;
   logic                rsp_valid_ff;
   logic [W-1:0]        res_ff;
   logic                st_ff, eq_ff;

   function automatic logic [W-1:0] add_m(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] md);
      logic [W:0] s;
      logic [W:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, md};
      return d[W] ? s[W-1:0] : d[W-1:0];
   endfunction

   function automatic logic [W-1:0] sub_m(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] md);
      logic [W:0] d;
      d = {1'b0, a} - {1'b0, b};
      return d[W] ? (d[W-1:0] + md) : d[W-1:0];
   endfunction

   assign meff = (mod_ff == '0) ? W'(1) : mod_ff;

   mau_divider #(.W(W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (opx_ff),
      .den   (opy_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   mau_mulmod #(.W(W)) u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go_ff),
      .x     (opx_ff),
      .y     (opy_ff),
      .m     (meff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mod_ff       <= W'(1);
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         if (csr_we) mod_ff <= csr_wdata[W-1:0];
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff    <= req_data.action;
                  braw_ff   <= req_data.operand_b[W-1:0];
                  e_ff      <= req_data.exponent;
                  opx_ff    <= req_data.operand_a[W-1:0];
                  opy_ff    <= meff;
                  div_go_ff <= 1'b1;
                  res_ff    <= '0;
                  st_ff     <= 1'b0;
                  eq_ff     <= 1'b0;
                  state_ff  <= S_RED_A;
               end
            end
            S_RED_A: begin
               if (div_done) begin
                  a_ff      <= div_rem;
                  opx_ff    <= braw_ff;
                  div_go_ff <= 1'b1;
                  state_ff  <= S_RED_B;
               end
            end
            S_RED_B: begin
               if (div_done) begin
                  b_ff     <= div_rem;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               // euclid set-up shared by div, inverse and negative power
               r0_ff <= meff;
               t0_ff <= '0;
               t1_ff <= W'(1);
               case (act_ff)
                  mau_pkg::ACT_ADD: begin
                     res_ff       <= add_m(a_ff, b_ff, meff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  mau_pkg::ACT_SUB: begin
                     res_ff       <= sub_m(a_ff, b_ff, meff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  mau_pkg::ACT_NEG: begin
                     res_ff       <= sub_m('0, a_ff, meff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  mau_pkg::ACT_MUL: begin
                     opx_ff    <= a_ff;
                     opy_ff    <= b_ff;
                     mul_go_ff <= 1'b1;
                     state_ff  <= S_MUL_FIN;
                  end
                  mau_pkg::ACT_DIV: begin
                     r1_ff    <= b_ff;
                     state_ff <= S_INV_LOOP;
                  end
                  mau_pkg::ACT_INV: begin
                     r1_ff    <= a_ff;
                     state_ff <= S_INV_LOOP;
                  end
                  mau_pkg::ACT_POW: begin
                     if (meff == W'(1)) begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else if (e_ff[EB-1]) begin
                        mag_ff   <= ~e_ff + 1'b1;
                        r1_ff    <= a_ff;
                        state_ff <= S_INV_LOOP;
                     end else begin
                        mag_ff   <= e_ff;
                        base_ff  <= a_ff;
                        acc_ff   <= W'(1);
                        state_ff <= S_POW;
                     end
                  end
                  default: begin
                     eq_ff        <= (a_ff == b_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               endcase
            end
            S_INV_LOOP: begin
               if (r1_ff == '0) begin
                  if (r0_ff != W'(1)) begin
                     st_ff        <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else if (act_ff == mau_pkg::ACT_DIV) begin
                     opx_ff    <= a_ff;
                     opy_ff    <= t0_ff;
                     mul_go_ff <= 1'b1;
                     state_ff  <= S_MUL_FIN;
                  end else if (act_ff == mau_pkg::ACT_POW) begin
                     base_ff  <= t0_ff;
                     acc_ff   <= W'(1);
                     state_ff <= S_POW;
                  end else begin
                     res_ff       <= t0_ff;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  opx_ff    <= r0_ff;
                  opy_ff    <= r1_ff;
                  div_go_ff <= 1'b1;
                  state_ff  <= S_INV_DIV;
               end
            end
            S_INV_DIV: begin
               if (div_done) begin
                  r2_ff     <= div_rem;
                  // quotient equals the modulus only on the first step
                  opx_ff    <= (div_quo == meff) ? '0 : div_quo;
                  opy_ff    <= t1_ff;
                  mul_go_ff <= 1'b1;
                  state_ff  <= S_INV_MUL;
               end
            end
            S_INV_MUL: begin
               if (mul_done) begin
                  t1_ff    <= sub_m(t0_ff, mul_prod, meff);
                  t0_ff    <= t1_ff;
                  r0_ff    <= r1_ff;
                  r1_ff    <= r2_ff;
                  state_ff <= S_INV_LOOP;
               end
            end
            S_POW: begin
               if (mag_ff == '0) begin
                  res_ff       <= acc_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (mag_ff[0]) begin
                  opx_ff    <= acc_ff;
                  opy_ff    <= base_ff;
                  mul_go_ff <= 1'b1;
                  state_ff  <= S_POW_ACC;
               end else begin
                  state_ff <= S_POW_SQ;
               end
            end
            S_POW_ACC: begin
               if (mul_done) begin
                  acc_ff   <= mul_prod;
                  state_ff <= S_POW_SQ;
               end
            end
            S_POW_SQ: begin
               opx_ff    <= base_ff;
               opy_ff    <= base_ff;
               mul_go_ff <= 1'b1;
               state_ff  <= S_POW_SQW;
            end
            S_POW_SQW: begin
               if (mul_done) begin
                  base_ff  <= mul_prod;
                  mag_ff   <= mag_ff >> 1;
                  state_ff <= S_POW;
               end
            end
            S_MUL_FIN: begin
               if (mul_done) begin
                  res_ff       <= mul_prod;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.result_value = mau_pkg::VALUE_BITS'(res_ff);
   assign rsp_data.status       = st_ff;
   assign rsp_data.is_equal     = eq_ff;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modular arithmetic unit. A scoreboard model
// predicts every transaction over a sequence of moduli, from zero up to the
// widest value, with directed corner cases followed by random traffic.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [62:0] MAX_VAL = {63{1'b1}};

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   mau_pkg::req_type   req_data;
   logic               rsp_valid;
   mau_pkg::rsp_type   rsp_data;
   logic               csr_we;
   logic [62:0]        csr_wdata;

   mau_pkg::req_type   pending_q[$];
   mau_pkg::rsp_type   expected_q[$];
   logic [62:0]        cur_modulus;
   int                 err_count;
   int                 rsp_count;
   int                 sent_count;
   int                 send_idle_pct;

   modular_arithmetic_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
      logic [63:0] s;
      s = a + b;
      return (s >= m) ? s - m : s;
   endfunction

   function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
      return (a >= b) ? a - b : a + (m - b);
   endfunction

   function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
      logic [127:0] p;
      p = a * b;
      return 64'(p % m);
   endfunction

   // extended euclid with the coefficient kept reduced
   function automatic bit mod_inv(logic [63:0] a, logic [63:0] m,
                                  output logic [63:0] inv);
      logic [63:0] r0, r1, r2, t0, t1, t2, q;
      r0 = m; r1 = a; t0 = 0; t1 = 1;
      inv = 0;
      if (m == 1) return 1'b1;
      while (r1 != 0) begin
         q  = r0 / r1;
         r2 = r0 - q * r1;
         t2 = mod_sub(t0, mod_mul(q % m, t1, m), m);
         r0 = r1; r1 = r2; t0 = t1; t1 = t2;
      end
      if (r0 != 1) return 1'b0;
      inv = t0;
      return 1'b1;
   endfunction

   function automatic mau_pkg::rsp_type predict_result(mau_pkg::req_type r,
                                                       logic [62:0] modulus);
      logic [63:0]      m, a, b, tmp, base, acc, mag;
      mau_pkg::rsp_type o;
      m = (modulus == 0) ? 64'd1 : {1'b0, modulus};
      a = {1'b0, r.operand_a} % m;
      b = {1'b0, r.operand_b} % m;
      o = '0;
      case (r.action)
         mau_pkg::ACT_ADD: o.result_value = 63'(mod_add(a, b, m));
         mau_pkg::ACT_SUB: o.result_value = 63'(mod_sub(a, b, m));
         mau_pkg::ACT_NEG: o.result_value = 63'(mod_sub(0, a, m));
         mau_pkg::ACT_MUL: o.result_value = 63'(mod_mul(a, b, m));
         mau_pkg::ACT_DIV: begin
            if (mod_inv(b, m, tmp)) o.result_value = 63'(mod_mul(a, tmp, m));
            else o.status = 1'b1;
         end
         mau_pkg::ACT_INV: begin
            if (mod_inv(a, m, tmp)) o.result_value = 63'(tmp);
            else o.status = 1'b1;
         end
         mau_pkg::ACT_POW: begin
            if (m != 1) begin
               base = a;
               mag  = r.exponent;
               if (r.exponent[63]) begin
                  mag = ~r.exponent + 64'd1;
                  if (!mod_inv(a, m, base)) o.status = 1'b1;
               end
               if (!o.status) begin
                  acc = 1;
                  while (mag != 0) begin
                     if (mag[0]) acc = mod_mul(acc, base, m);
                     base = mod_mul(base, base, m);
                     mag = mag >> 1;
                  end
                  o.result_value = 63'(acc);
               end
            end
         end
         default: o.is_equal = (a == b);
      endcase
      return o;
   endfunction

   // --------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // previous transaction finished: busy fell at the last rising edge
         start <= 1'b0;
      end else if (!start && pending_q.size() > 0 &&
                   $urandom_range(99, 0) >= send_idle_pct) begin
         req_data <= pending_q.pop_front();
         start    <= 1'b1;
      end
   end

   // model the transaction at the edge it is taken
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_q.push_back(predict_result(req_data, cur_modulus));
         sent_count++;
      end
   end

   // -------------------------------------------------------------- monitor
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
      $display("mismatch %s: got %h expected %h (response %0d)", what, got, exp,
               rsp_count);
      err_count++;
   endtask

   always @(posedge clock) begin
      mau_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_data), 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_data.result_value !== e.result_value)
               report_mismatch("result_value", 64'(rsp_data.result_value),
                               64'(e.result_value));
            if (rsp_data.status !== e.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(e.status));
            if (rsp_data.is_equal !== e.is_equal)
               report_mismatch("is_equal", 64'(rsp_data.is_equal), 64'(e.is_equal));
         end
         rsp_count++;
      end
   end

   // ------------------------------------------------------------- stimulus
   function automatic logic [62:0] rand_val();
      logic [62:0] v;
      v = 63'({$urandom, $urandom});
      case ($urandom_range(4, 0))
         0: v = v % 64;
         1: v = MAX_VAL - (v % 4);
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] rand_exp();
      logic [63:0] e;
      e = {$urandom, $urandom};
      case ($urandom_range(5, 0))
         0: e = e % 16;
         1: e = -(e % 16);
         2: e = {1'b1, 63'd0};
         default: ;
      endcase
      return e;
   endfunction

   task automatic queue_item(mau_pkg::action_type act, logic [62:0] a,
                             logic [62:0] b, logic [63:0] e);
      mau_pkg::req_type r;
      r.action    = act;
      r.operand_a = a;
      r.operand_b = b;
      r.exponent  = e;
      pending_q.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_q.size() > 0 || start || expected_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_modulus(logic [62:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_modulus = value;
   endtask

   task automatic random_items(int n);
      repeat (n) queue_item(mau_pkg::action_type'($urandom_range(7, 0)), rand_val(),
                            rand_val(), rand_exp());
   endtask

   initial begin
      logic [62:0] moduli[6];
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      cur_modulus = 63'd1;
      err_count   = 0;
      rsp_count   = 0;
      sent_count  = 0;
      send_idle_pct = 10;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset modulus of one: everything collapses to zero
      queue_item(mau_pkg::ACT_ADD, MAX_VAL, 63'd5, 0);
      queue_item(mau_pkg::ACT_INV, 63'd7, 0, 0);
      queue_item(mau_pkg::ACT_POW, 63'd3, 0, 64'd0);
      wait_drained();

      // directed corners on a prime and on a composite
      write_modulus(63'd1000003);
      queue_item(mau_pkg::ACT_ADD, MAX_VAL, MAX_VAL, 0);
      queue_item(mau_pkg::ACT_SUB, 0, MAX_VAL, 0);
      queue_item(mau_pkg::ACT_NEG, 0, 0, 0);
      queue_item(mau_pkg::ACT_NEG, MAX_VAL, 0, 0);
      queue_item(mau_pkg::ACT_MUL, MAX_VAL, MAX_VAL, 0);
      queue_item(mau_pkg::ACT_DIV, 63'd5, 63'd1000003, 0);
      queue_item(mau_pkg::ACT_DIV, 63'd5, 63'd3, 0);
      queue_item(mau_pkg::ACT_INV, 63'd2, 0, 0);
      queue_item(mau_pkg::ACT_INV, 0, 0, 0);
      queue_item(mau_pkg::ACT_POW, 63'd2, 0, 64'd0);
      queue_item(mau_pkg::ACT_POW, 63'd2, 0, {1'b1, 63'd0});
      queue_item(mau_pkg::ACT_POW, 63'd2, 0, {64{1'b1}});
      queue_item(mau_pkg::ACT_POW, 0, 0, -64'sd3);
      queue_item(mau_pkg::ACT_EQ, 63'd1000004, 63'd1, 0);
      queue_item(mau_pkg::ACT_EQ, 63'd4, 63'd1, 0);
      wait_drained();
      write_modulus(63'd0);
      queue_item(mau_pkg::ACT_MUL, 63'd9, 63'd9, 0);
      wait_drained();
      write_modulus(63'd360);
      queue_item(mau_pkg::ACT_DIV, 63'd7, 63'd12, 0);
      queue_item(mau_pkg::ACT_POW, 63'd6, 0, -64'sd1);

      // one pause until all results are back
      wait_drained();

      moduli = '{MAX_VAL, 63'h7FFF_FFFF_FFFF_FFE7, 63'd97, 63'd2,
                 63'h5555_AAAA_1234_5679, 63'd1 << 40};
      for (int i = 0; i < 6; i++) begin
         write_modulus(moduli[i]);
         if (i == 2) send_idle_pct = 86;
         if (i == 4) send_idle_pct = 0;
         random_items(17);
         wait_drained();
      end

      $display("covered %0d transactions, %0d responses, over moduli from 0 to 2^63-1",
               sent_count, rsp_count);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout with %0d responses outstanding", expected_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
